// ===== sv/scope_trigger_autoscale_defines.svh =====
// Assertion macros shared by the scope trigger and autoscale RTL.
`ifndef SCOPE_TRIGGER_AUTOSCALE_DEFINES_SVH
`define SCOPE_TRIGGER_AUTOSCALE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define STA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define STA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sta_pkg.sv =====
// Package: payload types, constants and helpers of the scope trigger block.
package sta_pkg;

    localparam int FRAME_SAMPLES_DEF = 300;
    localparam int SEARCH_WINDOW_DEF = 200;

    localparam logic [16:0] FIVE_Q14    = 17'd81920;
    localparam logic [19:0] HALF5_X4    = 20'd163840;
    localparam logic [15:0] ROW_MID_Q8  = 16'd7680;
    localparam logic [11:0] ROW_GAIN    = 12'd2880;
    localparam logic [19:0] RECIP_TEN   = 20'd838861;
    localparam int          RECIP_SHIFT = 23;

    localparam logic [15:0] LEVEL_RST   = 16'd16384;
    localparam logic [16:0] MIN_VPP_RST = 17'd4915;

    localparam logic REG_TRIGGER_LEVEL = 1'b0;
    localparam logic REG_MIN_VPP       = 1'b1;

    typedef struct packed {
        logic        func;
        logic [11:0] sample;
        logic [6:0]  point;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] row;
        logic [7:0]         trigger_index;
        logic [16:0]        peak_value;
        logic               small_signal;
    } t_out_item;

    // ADC code to Q2.14 volts: (code * 132 + 5) / 10, divide by reciprocal
    function automatic logic [15:0] code_to_volts(input logic [11:0] code);
        logic [19:0] n;
        logic [39:0] prod;
        n    = 20'(code) * 20'd132 + 20'd5;
        prod = 40'(n) * 40'(RECIP_TEN);
        return prod[RECIP_SHIFT +: 16];
    endfunction

endpackage

// ===== sv/scope_trigger_autoscale.sv =====
// Top level: scope edge trigger and autoscale with sample store and display row divider.
// Loads one 12-bit ADC code per func=0 item and returns one display row per func=1
// item. A load passes through accept, volts conversion, then store and trigger/peak
// update, and gives no result. A read passes through accept, index wrap by repeated
// subtraction of the frame length, one memory read, volts, offset and rounded
// numerator magnitude, the restoring divider by the scale peak (skipped when the
// scale is zero), then sign, saturation and the registered row. The index wrap and
// the divider share a single subtractor. o_in_stall is high for the whole of an
// item; a finished row waits in the output register, and loads go on while it
// waits. The sample store has no reset; a read of a never written entry is
// undefined. Configuration is over a small APB port: trigger_level at 0x0, min_vpp
// at 0x4. The trigger index and scale update only at frame end.
`include "scope_trigger_autoscale_defines.svh"

module scope_trigger_autoscale
    import sta_pkg::*;
#(
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF,
    parameter int SEARCH_WINDOW = SEARCH_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW   = $clog2(FRAME_SAMPLES);   // sample position width
    localparam int IW   = TW + 2;                  // trigger + point before wrap
    localparam int SW   = (IW > 18) ? IW : 18;     // shared subtractor width
    localparam int DW   = 30;                      // divider dividend width
    localparam int CW   = $clog2(DW);
    localparam bit SEARCH_ALL = (SEARCH_WINDOW >= FRAME_SAMPLES);
    localparam int SEARCH_LIM = SEARCH_ALL ? FRAME_SAMPLES - 1 : SEARCH_WINDOW;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_LD_V    = 10'b00_0000_0010,
        ST_LD_UPD  = 10'b00_0000_0100,
        ST_RD_WRAP = 10'b00_0000_1000,
        ST_RD_MEM  = 10'b00_0001_0000,
        ST_RD_X    = 10'b00_0010_0000,
        ST_RD_MAG  = 10'b00_0100_0000,
        ST_RD_DIV  = 10'b00_1000_0000,
        ST_RD_FIN  = 10'b01_0000_0000,
        ST_RD_WAIT = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        TP_BELOW = 3'b001,
        TP_ABOVE = 3'b010,
        TP_FOUND = 3'b100
    } t_trig_phase;

    // configuration registers
    logic [15:0] r_level;
    logic [16:0] r_min_vpp;

    // control state
    t_state      r_state,     n_state;
    t_trig_phase r_phase,     n_phase;
    logic [TW-1:0] r_wpos,    n_wpos;
    logic [TW-1:0] r_cand,    n_cand;
    logic [TW-1:0] r_trig,    n_trig;
    logic [16:0] r_run_peak,  n_run_peak;
    logic [16:0] r_frame_peak, n_frame_peak;
    logic [16:0] r_scale,     n_scale;
    logic [CW-1:0] r_cnt,     n_cnt;
    logic        r_out_valid, n_out_valid;

    // datapath registers
    logic [11:0]        r_code,  n_code;
    logic [15:0]        r_v,     n_v;
    logic [IW-1:0]      r_idx,   n_idx;
    logic signed [19:0] r_x,     n_x;
    logic               r_neg,   n_neg;
    logic [DW-1:0]      r_dvd,   n_dvd;
    logic [16:0]        r_rem,   n_rem;
    t_out_item          r_out,   n_out;

    // sample store
    logic [11:0] r_mem [FRAME_SAMPLES];
    logic [11:0] r_rd_code;

    // shared subtractor
    logic [SW-1:0] s_sub_a, s_sub_b;
    logic [SW:0]   s_sub_d;
    logic          s_borrow;

    logic          s_in_acc;
    logic          s_out_acc;
    logic          s_cfg_wr;
    logic [16:0]   s_pk;
    logic [16:0]   s_v2;
    logic          s_in_win;
    logic [17:0]   s_trial;
    logic [18:0]   s_xmag;
    logic [30:0]   s_num;
    logic signed [31:0] s_q;
    logic signed [31:0] s_row;
    logic signed [15:0] s_row_sat;

    assign s_in_acc  = i_in_valid && !o_in_stall;
    assign s_out_acc = r_out_valid && !i_out_stall;
    assign s_cfg_wr  = psel && penable && pwrite && pready;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;

    // register readback
    always_comb begin
        case (paddr[2])
            REG_TRIGGER_LEVEL: prdata = {16'd0, r_level};
            REG_MIN_VPP:       prdata = {15'd0, r_min_vpp};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= LEVEL_RST;
            r_min_vpp <= MIN_VPP_RST;
        end else if (s_cfg_wr) begin
            case (paddr[2])
                REG_TRIGGER_LEVEL: r_level   <= pwdata[15:0];
                REG_MIN_VPP:       r_min_vpp <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Shared unit: index wrap against the frame length, or one divider step
    always_comb begin
        s_trial = {r_rem, r_dvd[DW-1]};
        if (r_state == ST_RD_DIV) begin
            s_sub_a = SW'(s_trial);
            s_sub_b = SW'(r_scale);
        end else begin
            s_sub_a = SW'(r_idx);
            s_sub_b = SW'(FRAME_SAMPLES);
        end
        s_sub_d  = {1'b0, s_sub_a} - {1'b0, s_sub_b};
        s_borrow = s_sub_d[SW];
    end

    // load-side peak and trigger window
    assign s_v2     = {r_v, 1'b0};
    assign s_pk     = (s_v2 >= FIVE_Q14) ? 17'd0 : FIVE_Q14 - s_v2;
    assign s_in_win = SEARCH_ALL || (r_wpos < TW'(SEARCH_LIM));

    // read-side numerator magnitude, signed quotient, row and saturation
    assign s_xmag = r_x[19] ? 19'(-r_x) : 19'(r_x);
    assign s_num  = 31'(s_xmag) * 31'(ROW_GAIN) + 31'(r_scale[16:1]);
    assign s_q    = r_neg ? -$signed({2'b00, r_dvd}) : $signed({2'b00, r_dvd});
    assign s_row  = $signed({16'd0, ROW_MID_Q8}) - s_q;

    always_comb begin
        if (r_scale == 17'd0)
            s_row_sat = $signed(ROW_MID_Q8);
        else if (s_row > 32'sd32767)
            s_row_sat = 16'sh7FFF;
        else if (s_row < -32'sd32768)
            s_row_sat = -16'sh8000;
        else
            s_row_sat = s_row[15:0];
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_wpos       = r_wpos;
        n_cand       = r_cand;
        n_trig       = r_trig;
        n_run_peak   = r_run_peak;
        n_frame_peak = r_frame_peak;
        n_scale      = r_scale;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_code       = r_code;
        n_v          = r_v;
        n_idx        = r_idx;
        n_x          = r_x;
        n_neg        = r_neg;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_out        = r_out;

        // drop the held row once taken
        if (s_out_acc)
            n_out_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_in_acc) begin
                    n_code = i_in_item.sample;
                    n_idx  = IW'(r_trig) + IW'(i_in_item.point);
                    n_state = i_in_item.func ? ST_RD_WRAP : ST_LD_V;
                end
            end
            ST_LD_V: begin
                n_v     = code_to_volts(r_code);
                n_state = ST_LD_UPD;
            end
            ST_LD_UPD: begin
                if (s_pk > r_run_peak)
                    n_run_peak = s_pk;
                if (s_in_win) begin
                    case (r_phase)
                        TP_BELOW: if (r_v < r_level) n_phase = TP_ABOVE;
                        TP_ABOVE: begin
                            if (r_v > r_level) begin
                                n_cand  = r_wpos;
                                n_phase = TP_FOUND;
                            end
                        end
                        TP_FOUND: ;
                        default:  n_phase = TP_BELOW;
                    endcase
                end
                if (r_wpos == TW'(FRAME_SAMPLES - 1)) begin
                    // frame end: commit trigger and peak, restart search
                    if (r_phase == TP_FOUND)
                        n_trig = r_cand;
                    n_frame_peak = (s_pk > r_run_peak) ? s_pk : r_run_peak;
                    if (n_frame_peak > r_min_vpp)
                        n_scale = n_frame_peak;
                    n_run_peak = 17'd0;
                    n_phase    = TP_BELOW;
                    n_cand     = '0;
                    n_wpos     = '0;
                end else begin
                    n_wpos = r_wpos + TW'(1);
                end
                n_state = ST_IDLE;
            end
            ST_RD_WRAP: begin
                // subtract the frame length until the index lies in the store
                if (!s_borrow)
                    n_idx = IW'(s_sub_d);
                else
                    n_state = ST_RD_MEM;
            end
            ST_RD_MEM: begin
                n_v     = code_to_volts(r_rd_code);
                n_state = ST_RD_X;
            end
            ST_RD_X: begin
                n_x = $signed({2'b00, r_v, 2'b00}) - $signed(HALF5_X4)
                      + $signed({3'b000, r_scale});
                n_state = ST_RD_MAG;
            end
            ST_RD_MAG: begin
                n_neg = r_x[19];
                n_dvd = DW'(s_num);
                n_rem = 17'd0;
                n_cnt = '0;
                n_state = (r_scale == 17'd0) ? ST_RD_FIN : ST_RD_DIV;
            end
            ST_RD_DIV: begin
                // one restoring step: shift in a dividend bit, try the subtract
                if (!s_borrow) begin
                    n_rem = s_sub_d[16:0];
                    n_dvd = {r_dvd[DW-2:0], 1'b1};
                end else begin
                    n_rem = s_trial[16:0];
                    n_dvd = {r_dvd[DW-2:0], 1'b0};
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1))
                    n_state = ST_RD_FIN;
            end
            ST_RD_FIN: begin
                n_out.row           = s_row_sat;
                n_out.trigger_index = 8'(r_trig);
                n_out.peak_value    = r_frame_peak;
                n_out.small_signal  = (r_frame_peak <= r_min_vpp);
                n_state             = ST_RD_WAIT;
                // hold here while the previous row is still waiting
                if (r_out_valid && i_out_stall) begin
                    n_out   = r_out;
                    n_state = ST_RD_FIN;
                end else begin
                    n_out_valid = 1'b1;
                end
            end
            ST_RD_WAIT: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= TP_BELOW;
            r_wpos       <= '0;
            r_cand       <= '0;
            r_trig       <= '0;
            r_run_peak   <= 17'd0;
            r_frame_peak <= 17'd0;
            r_scale      <= 17'd0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_wpos       <= n_wpos;
            r_cand       <= n_cand;
            r_trig       <= n_trig;
            r_run_peak   <= n_run_peak;
            r_frame_peak <= n_frame_peak;
            r_scale      <= n_scale;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_v    <= n_v;
        r_idx  <= n_idx;
        r_x    <= n_x;
        r_neg  <= n_neg;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_out  <= n_out;
    end

    // sample store: write on load update, registered read after the wrap
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LD_UPD)
            r_mem[r_wpos] <= r_code;
    end

    always_ff @(posedge i_clk) begin
        r_rd_code <= r_mem[r_idx[TW-1:0]];
    end

    `STA_ASSERT_NOW(a_wpos_in_frame, i_clk, i_rst_n, 1'b1, r_wpos <= TW'(FRAME_SAMPLES - 1), "write position past frame end")
    `STA_ASSERT_NOW(a_rem_below_scale, i_clk, i_rst_n, r_state == ST_RD_DIV, r_rem < r_scale, "divider remainder not below scale peak")
    `STA_ASSERT_NEXT(a_row_lands, i_clk, i_rst_n, (r_state == ST_RD_FIN) && !(r_out_valid && i_out_stall), o_out_valid && (r_state == ST_RD_WAIT), "finished row not registered")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the scope trigger and autoscale block.
`timescale 1ns / 1ps

module tb_top;
    import sta_pkg::*;

    // Item operations; the package carries no names for them.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int          FRAME           = FRAME_SAMPLES_DEF;
    localparam int          WINDOW          = SEARCH_WINDOW_DEF;
    localparam int          POINT_MAX       = 99;
    localparam logic [15:0] LEVEL_MAX       = 16'd54067;
    localparam logic [16:0] MIN_VPP_MAX     = 17'd81920;
    // Settle time past the end of any read or load still in flight.
    localparam int          SETTLE_CYCLES   = 60;
    localparam int          LONG_HOLD       = 400;
    localparam int          STALL_LIMIT     = 5000;
    localparam int          RANDOM_PHASES   = 4;
    localparam int          ITEMS_PER_PHASE = 275;
    localparam int          IDLE_PCT        = 36;

    typedef enum logic [1:0] {SEEK_BELOW, SEEK_ABOVE, EDGE_FOUND} t_seek;
    typedef enum logic [1:0] {STEP_LOAD, STEP_READ, STEP_LEVEL, STEP_MIN_VPP} t_step_kind;
    typedef enum logic [1:0] {WAVE_SQUARE, WAVE_NOISE, WAVE_NARROW, WAVE_FLAT} t_wave;

    // One row of the directed plan.
    typedef struct packed {
        t_step_kind  kind;
        logic [11:0] code;
        logic [6:0]  point;
        logic [8:0]  count;   // loads: copies of code, 0 runs to the end of the frame
        logic [16:0] value;   // register value
        logic        typed;   // want holds the result, else the predictor does
        t_out_item   want;
    } t_step;

    // Results that follow straight from the register and frame contents.
    localparam t_out_item NO_SCALE_ROW = '{16'sd7680, 8'd0, 17'd0, 1'b1};
    localparam t_out_item ROW_SAT_HIGH = '{16'sh7FFF, 8'd1, 17'd28, 1'b0};
    localparam t_out_item ROW_SAT_LOW  = '{16'sh8000, 8'd1, 17'd28, 1'b0};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    scope_trigger_autoscale uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Shadow copy of the block: sample store, trigger search, peaks, registers.
    logic [11:0] shadow_samples [FRAME];
    bit          sample_written [FRAME];
    int unsigned shadow_wpos;
    int unsigned shadow_run_peak;
    int unsigned shadow_cand;
    int unsigned shadow_trig;
    int unsigned shadow_frame_peak;
    int unsigned shadow_scale;
    t_seek       shadow_seek;
    logic [15:0] shadow_level;
    logic [16:0] shadow_min_vpp;

    // Display rows still owed by the block, oldest first.
    t_out_item   pending_rows [$];
    int          mismatches;

    // Shared between the item sender and the row receiver.
    bit          steady_run;      // written by the sender: no idling on either side
    bit          long_hold_go;    // written by the sender: ask for one long hold-off
    bit          long_hold_done;  // written by the receiver
    int          hold_left;       // written by the receiver
    int          quiet_cycles;

    // Waveform generator state for the random frames.
    t_wave       wave;
    logic [11:0] sq_lo;
    logic [11:0] sq_hi;
    logic [11:0] wave_mid;
    int          sq_len;
    int          sq_left;
    bit          sq_high;

    // ADC code to Q2.14 volts, rounded half up.
    function automatic int unsigned volts_of(logic [11:0] code);
        return (int'(code) * 132 + 5) / 10;
    endfunction

    // Advance the shadow state by one loaded sample; commit at the end of a frame.
    function automatic void load_sample(logic [11:0] code);
        int unsigned v;
        int unsigned pk;
        int unsigned pos;
        v   = volts_of(code);
        pk  = (2 * v >= FIVE_Q14) ? 0 : FIVE_Q14 - 2 * v;
        pos = (shadow_wpos >= FRAME) ? 0 : shadow_wpos;
        shadow_samples[pos] = code;
        sample_written[pos] = 1'b1;
        if (pk > shadow_run_peak) shadow_run_peak = pk;
        // The sample that drops below the level is not tested against it again.
        if (pos < WINDOW) begin
            if (shadow_seek == SEEK_BELOW) begin
                if (v < shadow_level) shadow_seek = SEEK_ABOVE;
            end else if (shadow_seek == SEEK_ABOVE && v > shadow_level) begin
                shadow_cand = pos;
                shadow_seek = EDGE_FOUND;
            end
        end
        if (pos + 1 >= FRAME) begin
            if (shadow_seek == EDGE_FOUND) shadow_trig = shadow_cand;
            shadow_frame_peak = shadow_run_peak;
            if (shadow_run_peak > shadow_min_vpp) shadow_scale = shadow_run_peak;
            shadow_run_peak = 0;
            shadow_seek     = SEEK_BELOW;
            shadow_cand     = 0;
            shadow_wpos     = 0;
        end else begin
            shadow_wpos = pos + 1;
        end
    endfunction

    // Display row for trigger + point, scaled by the committed peak.
    function automatic t_out_item predict_read(logic [6:0] point);
        t_out_item res;
        longint    v;
        longint    x;
        longint    num;
        longint    q;
        longint    r;
        longint    p;
        p = shadow_scale;
        if (p == 0) begin
            r = longint'(ROW_MID_Q8);
        end else begin
            v   = volts_of(shadow_samples[(shadow_trig + point) % FRAME]);
            x   = 4 * v - longint'(HALF5_X4) + p;
            num = x * longint'(ROW_GAIN);
            // Round half away from zero.
            if (num >= 0) q = (num + p / 2) / p;
            else q = -((-num + p / 2) / p);
            r = longint'(ROW_MID_Q8) - q;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
        end
        res.row           = r[15:0];
        res.trigger_index = 8'(shadow_trig);
        res.peak_value    = 17'(shadow_frame_peak);
        res.small_signal  = (shadow_frame_peak <= shadow_min_vpp);
        return res;
    endfunction

    // Next code of the current random frame; a new waveform starts with each frame.
    function automatic logic [11:0] next_code();
        int lvl_code;
        int pick;
        if (shadow_wpos == 0) begin
            lvl_code = shadow_level * 10 / 132;
            if (lvl_code > 4095) lvl_code = 4095;
            pick = $urandom_range(0, 99);
            if (pick < 40) wave = WAVE_SQUARE;
            else if (pick < 60) wave = WAVE_NOISE;
            else if (pick < 85) wave = WAVE_NARROW;
            else wave = WAVE_FLAT;
            // Square waves straddle the level so the edge search gets exercised.
            sq_lo   = 12'($urandom_range(0, lvl_code));
            sq_hi   = 12'($urandom_range(lvl_code, 4095));
            sq_len  = $urandom_range(1, 40);
            sq_left = sq_len;
            sq_high = 1'($urandom_range(0, 1));
            // Narrow frames sit near mid-scale and give tiny peaks.
            wave_mid = (wave == WAVE_NARROW) ? 12'($urandom_range(3055, 3140))
                                             : 12'($urandom_range(0, 4095));
        end
        case (wave)
            WAVE_SQUARE: begin
                if (sq_left == 0) begin
                    sq_high = !sq_high;
                    sq_left = sq_len;
                end
                sq_left--;
                return sq_high ? sq_hi : sq_lo;
            end
            WAVE_NOISE:  return 12'($urandom_range(0, 4095));
            WAVE_NARROW: return 12'(wave_mid + $urandom_range(0, 6));
            default:     return wave_mid;
        endcase
    endfunction

    // Random item; a read whose store entry was never written becomes a load.
    function automatic t_in_item next_item(int read_pct);
        t_in_item it;
        it.sample = 12'($urandom_range(0, 4095));
        it.point  = 7'($urandom_range(0, POINT_MAX));
        it.func   = FUNC_LOAD;
        if ($urandom_range(0, 99) < read_pct && sample_written[(shadow_trig + it.point) % FRAME])
            it.func = FUNC_READ;
        else
            it.sample = next_code();
        return it;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_row(t_out_item got, t_out_item want);
        if (got.row !== want.row)
            flag_mismatch($sformatf("row got %0d want %0d", got.row, want.row));
        if (got.trigger_index !== want.trigger_index)
            flag_mismatch($sformatf("trigger_index got %0d want %0d",
                                    got.trigger_index, want.trigger_index));
        if (got.peak_value !== want.peak_value)
            flag_mismatch($sformatf("peak_value got %0d want %0d",
                                    got.peak_value, want.peak_value));
        if (got.small_signal !== want.small_signal)
            flag_mismatch($sformatf("small_signal got %0b want %0b",
                                    got.small_signal, want.small_signal));
    endtask

    // Offer one item, with random idle cycles ahead of it, and hold it until taken.
    // Valid is left high on acceptance so back-to-back items need no second drive.
    task automatic push_item(t_in_item it, bit typed, t_out_item want);
        if (!steady_run) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (it.func == FUNC_READ)
            pending_rows.push_back(typed ? want : predict_read(it.point));
        else
            load_sample(it.sample);
    endtask

    // Drop valid and wait for every owed row; it always waits on the clock before it checks.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rows.size() != 0);
    endtask

    // Register write on an idle block: setup phase, then access phase until pready.
    task automatic write_reg(logic idx, logic [16:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_TRIGGER_LEVEL) shadow_level = value[15:0];
        else shadow_min_vpp = value;
    endtask

    // Row receiver: check each taken row against the oldest owed one, then pick
    // the stall for the next cycle (long hold-off, steady run or random).
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rows.size() == 0)
                flag_mismatch($sformatf("unexpected result, row %0d", o_out_item.row));
            else
                compare_row(o_out_item, pending_rows.pop_front());
        end
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (long_hold_go && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            i_out_stall    <= 1'b1;
        end else if (steady_run) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_step       plan [$];
        t_in_item    it;
        t_out_item   none;
        int          n;
        logic [15:0] level_pick;
        logic [16:0] min_pick;

        // Directed plan. Store entries are always written before they are read.
        plan = '{
            // No scale yet: two samples, then reads of both give the flat row.
            '{STEP_LOAD,    12'd0,    7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd4095, 7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd0,  9'd0,   17'd0,     1'b1, NO_SCALE_ROW},
            '{STEP_READ,    12'd0,    7'd1,  9'd0,   17'd0,     1'b1, NO_SCALE_ROW},
            // Finish the frame: edge at sample 1, full-scale peak.
            '{STEP_LOAD,    12'd2048, 7'd0,  9'd0,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd0,  9'd0,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd99, 9'd0,   17'd0,     1'b0, '0},
            // Level above any code: trigger is kept. Flat mid-scale frame, tiny peak.
            '{STEP_LEVEL,   12'd0,    7'd0,  9'd0,   17'(LEVEL_MAX), 1'b0, '0},
            '{STEP_MIN_VPP, 12'd0,    7'd0,  9'd0,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd3102, 7'd0,  9'd0,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd0,  9'd0,   17'd0,     1'b0, '0},
            // Stale reads during the next frame saturate both ways.
            '{STEP_LOAD,    12'd3102, 7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd0,    7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd0,  9'd0,   17'd0,     1'b1, ROW_SAT_HIGH},
            '{STEP_LOAD,    12'd4095, 7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd1,  9'd0,   17'd0,     1'b1, ROW_SAT_LOW},
            '{STEP_READ,    12'd0,    7'd99, 9'd0,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd3102, 7'd0,  9'd0,   17'd0,     1'b0, '0},
            // Largest min_vpp: small signal, scale kept. Level zero never triggers.
            '{STEP_MIN_VPP, 12'd0,    7'd0,  9'd0,   MIN_VPP_MAX, 1'b0, '0},
            '{STEP_LEVEL,   12'd0,    7'd0,  9'd0,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd2048, 7'd0,  9'd0,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd5,  9'd0,   17'd0,     1'b0, '0},
            // Level equal to code 2048: equal is not above, so the edge lands on
            // the last window sample.
            '{STEP_LEVEL,   12'd0,    7'd0,  9'd0,   17'd27034, 1'b0, '0},
            '{STEP_LOAD,    12'd4095, 7'd0,  9'd197, 17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd0,    7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd2048, 7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd4095, 7'd0,  9'd1,   17'd0,     1'b0, '0},
            '{STEP_LOAD,    12'd2048, 7'd0,  9'd0,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd99, 9'd0,   17'd0,     1'b0, '0},
            '{STEP_READ,    12'd0,    7'd0,  9'd0,   17'd0,     1'b0, '0}
        };

        none           = '0;
        mismatches     = 0;
        steady_run     = 1'b0;
        long_hold_go   = 1'b0;
        long_hold_done = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        wave           = WAVE_FLAT;
        wave_mid       = '0;
        sq_lo          = '0;
        sq_hi          = '0;
        sq_len         = 1;
        sq_left        = 0;
        sq_high        = 1'b0;

        // Shadow state after reset.
        foreach (sample_written[k]) sample_written[k] = 1'b0;
        foreach (shadow_samples[k]) shadow_samples[k] = '0;
        shadow_wpos       = 0;
        shadow_run_peak   = 0;
        shadow_cand       = 0;
        shadow_trig       = 0;
        shadow_frame_peak = 0;
        shadow_scale      = 0;
        shadow_seek       = SEEK_BELOW;
        shadow_level      = LEVEL_RST;
        shadow_min_vpp    = MIN_VPP_RST;

        // Hold every input at a known value from time zero.
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed plan.
        foreach (plan[s]) begin
            case (plan[s].kind)
                STEP_LEVEL:   write_reg(REG_TRIGGER_LEVEL, plan[s].value);
                STEP_MIN_VPP: write_reg(REG_MIN_VPP, plan[s].value);
                STEP_READ: begin
                    it.func   = FUNC_READ;
                    it.sample = 12'($urandom_range(0, 4095));
                    it.point  = plan[s].point;
                    push_item(it, plan[s].typed, plan[s].want);
                end
                default: begin
                    n = 0;
                    do begin
                        it.func   = FUNC_LOAD;
                        it.sample = plan[s].code;
                        it.point  = 7'($urandom_range(0, 127));
                        push_item(it, 1'b0, none);
                        n++;
                    end while (plan[s].count == 0 ? shadow_wpos != 0 : n < plan[s].count);
                end
            endcase
        end

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       level_pick = '0;
                1:       level_pick = LEVEL_MAX;
                2:       level_pick = LEVEL_RST;
                default: level_pick = 16'($urandom_range(0, LEVEL_MAX));
            endcase
            case ($urandom_range(0, 3))
                0:       min_pick = '0;
                1:       min_pick = MIN_VPP_MAX;
                2:       min_pick = MIN_VPP_RST;
                default: min_pick = 17'($urandom_range(0, MIN_VPP_MAX));
            endcase
            write_reg(REG_TRIGGER_LEVEL, 17'(level_pick));
            write_reg(REG_MIN_VPP, min_pick);
            // Last phase runs with no idling on either side.
            steady_run = (ph == RANDOM_PHASES - 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Stall the receiver for a long stretch; lean on reads so the
                // block backs up into its input.
                if (ph == 1 && k == 100) long_hold_go = 1'b1;
                // Pause the sender until every owed row is back.
                if (ph == 2 && k == 150) drain_results();
                push_item(next_item(hold_left > 0 ? 70 : 30), 1'b0, none);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== scope_trigger_autoscale.f =====
+incdir+sv
sv/sta_pkg.sv
sv/scope_trigger_autoscale.sv
dv/tb_top.sv
